FILE: design/scq_pkg.sv
package scq_pkg;

	localparam int unsigned CAPACITY_DEF = 8;
	localparam int unsigned VAL_W        = 32;
	localparam int unsigned OP_W         = 2;
	localparam int unsigned OCC_W        = 4;

	typedef enum logic [OP_W-1:0] {
		OP_APPEND = 2'd0,
		OP_INSERT = 2'd1,
		OP_REMOVE = 2'd2,
		OP_SEARCH = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_REM_WAIT,
		ST_SCAN_RD,
		ST_SCAN_CMP,
		ST_SH_RD,
		ST_SH_WR,
		ST_PUT,
		ST_DONE
	} state_t;

	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_LATCH,
		CMD_APPEND,
		CMD_INS_FIRST,
		CMD_REM_ONE,
		CMD_REM_RD,
		CMD_REM_FIN,
		CMD_SCAN_INIT,
		CMD_SCAN_RD,
		CMD_SCAN_NEXT,
		CMD_HIT,
		CMD_POS_HERE,
		CMD_POS_REAR,
		CMD_SH_RD,
		CMD_SH_WR,
		CMD_PUT
	} cmd_code_t;

	typedef struct packed {
		cmd_code_t code;
		logic      load_out;
	} dp_cmd_t;

	typedef struct packed {
		op_t  op;
		logic empty;
		logic full;
		logic last_one;
		logic gt;
		logic eq;
		logic scan_last;
		logic shift_last;
		logic out_free;
	} dp_stat_t;

endpackage

FILE: design/scq_ram.sv
module scq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/scq_ctrl.sv
module scq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  scq_pkg::dp_stat_t stat,
	output scq_pkg::dp_cmd_t  cmd
);
	import scq_pkg::*;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				unique case (stat.op)
					OP_APPEND: state_d = ST_DONE;
					OP_INSERT: state_d = (stat.full || stat.empty) ? ST_DONE : ST_SCAN_RD;
					OP_REMOVE: state_d = (stat.empty || stat.last_one) ? ST_DONE : ST_REM_WAIT;
					OP_SEARCH: state_d = stat.empty ? ST_DONE : ST_SCAN_RD;
					default:   state_d = ST_DONE;
				endcase
			end
			ST_REM_WAIT: state_d = ST_DONE;
			ST_SCAN_RD:  state_d = ST_SCAN_CMP;
			ST_SCAN_CMP: begin
				if (stat.op == OP_SEARCH) begin
					state_d = (stat.eq || stat.scan_last) ? ST_DONE : ST_SCAN_RD;
				end else if (stat.gt) begin
					state_d = ST_SH_RD;
				end else if (stat.scan_last) begin
					state_d = ST_PUT;
				end else begin
					state_d = ST_SCAN_RD;
				end
			end
			ST_SH_RD: state_d = ST_SH_WR;
			ST_SH_WR: state_d = stat.shift_last ? ST_PUT : ST_SH_RD;
			ST_PUT:   state_d = ST_DONE;
			ST_DONE: begin
				if (stat.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready     = 1'b0;
		cmd.code     = CMD_NONE;
		cmd.load_out = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) cmd.code = CMD_LATCH;
			end
			ST_DECIDE: begin
				unique case (stat.op)
					OP_APPEND: cmd.code = stat.full ? CMD_NONE : CMD_APPEND;
					OP_INSERT: begin
						if (stat.full) cmd.code = CMD_NONE;
						else if (stat.empty) cmd.code = CMD_INS_FIRST;
						else cmd.code = CMD_SCAN_INIT;
					end
					OP_REMOVE: begin
						if (stat.empty) cmd.code = CMD_NONE;
						else if (stat.last_one) cmd.code = CMD_REM_ONE;
						else cmd.code = CMD_REM_RD;
					end
					OP_SEARCH: cmd.code = stat.empty ? CMD_NONE : CMD_SCAN_INIT;
					default:   cmd.code = CMD_NONE;
				endcase
			end
			ST_REM_WAIT: cmd.code = CMD_REM_FIN;
			ST_SCAN_RD:  cmd.code = CMD_SCAN_RD;
			ST_SCAN_CMP: begin
				if (stat.op == OP_SEARCH) begin
					if (stat.eq) cmd.code = CMD_HIT;
					else if (!stat.scan_last) cmd.code = CMD_SCAN_NEXT;
					else cmd.code = CMD_NONE;
				end else if (stat.gt) begin
					cmd.code = CMD_POS_HERE;
				end else if (stat.scan_last) begin
					cmd.code = CMD_POS_REAR;
				end else begin
					cmd.code = CMD_SCAN_NEXT;
				end
			end
			ST_SH_RD: cmd.code = CMD_SH_RD;
			ST_SH_WR: cmd.code = CMD_SH_WR;
			ST_PUT:   cmd.code = CMD_PUT;
			ST_DONE:  cmd.load_out = stat.out_free;
			default:  cmd.code = CMD_NONE;
		endcase
	end

endmodule

FILE: design/scq_dp.sv
module scq_dp #(
	parameter int unsigned CAPACITY = scq_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic [scq_pkg::OP_W-1:0]          opcode,
	input  logic signed [scq_pkg::VAL_W-1:0]  value,
	input  scq_pkg::dp_cmd_t                  cmd,
	output scq_pkg::dp_stat_t                 stat,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              accepted,
	output logic                              found,
	output logic signed [scq_pkg::VAL_W-1:0]  front_value,
	output logic signed [scq_pkg::VAL_W-1:0]  rear_value,
	output logic [scq_pkg::OCC_W-1:0]         occupancy,
	output logic                              is_empty,
	output logic                              is_full
);
	import scq_pkg::*;

	localparam int unsigned AW = $clog2(CAPACITY);
	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic [AW-1:0]           head_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           idx_q;
	logic [CW-1:0]           pos_q;
	op_t                     op_q;
	logic signed [VAL_W-1:0] val_q;
	logic signed [VAL_W-1:0] front_q;
	logic signed [VAL_W-1:0] rear_q;
	logic                    acc_q;
	logic                    found_q;
	logic                    out_valid_q;

	logic                    we;
	logic [AW-1:0]           waddr;
	logic [VAL_W-1:0]        wdata;
	logic [AW-1:0]           raddr;
	logic [VAL_W-1:0]        rdata;
	logic                    empty;
	logic                    full;

	function automatic logic [AW-1:0] slot(input logic [AW-1:0] head, input logic [CW-1:0] off);
		logic [CW:0] sum;
		sum = (CW+1)'(head) + (CW+1)'(off);
		if (sum >= (CW+1)'(CAPACITY)) sum = sum - (CW+1)'(CAPACITY);
		return sum[AW-1:0];
	endfunction

	assign empty = (count_q == '0);
	assign full  = (count_q == CW'(CAPACITY));

	scq_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// ring port selection
	always_comb begin
		we    = 1'b0;
		waddr = slot(head_q, count_q);
		wdata = val_q;
		raddr = slot(head_q, idx_q);
		unique case (cmd.code)
			CMD_APPEND:    we = 1'b1;
			CMD_INS_FIRST: begin
				we    = 1'b1;
				waddr = head_q;
			end
			CMD_REM_RD: raddr = slot(head_q, CW'(1));
			CMD_SH_RD:  raddr = slot(head_q, idx_q - CW'(1));
			CMD_SH_WR: begin
				we    = 1'b1;
				waddr = slot(head_q, idx_q);
				wdata = rdata;
			end
			CMD_PUT: begin
				we    = 1'b1;
				waddr = slot(head_q, pos_q);
			end
			default: we = 1'b0;
		endcase
	end

	always_comb begin
		stat.op         = op_q;
		stat.empty      = empty;
		stat.full       = full;
		stat.last_one   = (count_q == CW'(1));
		stat.gt         = ($signed(rdata) > val_q);
		stat.eq         = (rdata == val_q);
		stat.scan_last  = ((idx_q + CW'(1)) == count_q);
		stat.shift_last = (idx_q == (pos_q + CW'(1)));
		stat.out_free   = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (cmd.code)
				CMD_APPEND, CMD_INS_FIRST, CMD_PUT: count_q <= count_q + CW'(1);
				CMD_REM_ONE, CMD_REM_FIN: begin
					head_q  <= slot(head_q, CW'(1));
					count_q <= count_q - CW'(1);
				end
				default: count_q <= count_q;
			endcase
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_LATCH: begin
				op_q    <= op_t'(opcode);
				val_q   <= value;
				acc_q   <= 1'b0;
				found_q <= 1'b0;
			end
			CMD_APPEND: begin
				acc_q  <= 1'b1;
				rear_q <= val_q;
				if (empty) front_q <= val_q;
			end
			CMD_INS_FIRST: begin
				acc_q   <= 1'b1;
				front_q <= val_q;
				rear_q  <= val_q;
			end
			CMD_REM_ONE, CMD_REM_RD: acc_q <= 1'b1;
			CMD_REM_FIN: front_q <= rdata;
			CMD_SCAN_INIT: begin
				acc_q <= 1'b1;
				idx_q <= '0;
			end
			CMD_SCAN_NEXT: idx_q <= idx_q + CW'(1);
			CMD_HIT:       found_q <= 1'b1;
			CMD_POS_HERE: begin
				pos_q <= idx_q;
				idx_q <= count_q;
			end
			CMD_POS_REAR: pos_q <= count_q;
			CMD_SH_WR:    idx_q <= idx_q - CW'(1);
			CMD_PUT: begin
				if (pos_q == '0) front_q <= val_q;
				if (pos_q == count_q) rear_q <= val_q;
			end
			default: idx_q <= idx_q;
		endcase
		if (cmd.load_out) begin
			accepted    <= acc_q;
			found       <= found_q;
			front_value <= empty ? '0 : front_q;
			rear_value  <= empty ? '0 : rear_q;
			occupancy   <= OCC_W'(count_q);
			is_empty    <= empty;
			is_full     <= full;
		end
	end

	assign out_valid = out_valid_q;

endmodule

FILE: design/sorted_circular_queue_top.sv
// channel | direction | handshake           | beat
// in      | in        | in_valid/in_ready   | opcode, value
// out     | out       | out_valid/out_ready | accepted, found, front/rear_value, occupancy, flags
//
// input beat to result beat: append, refused ops, insert into an empty queue and removing the
// last entry pass IDLE, DECIDE, DONE; other removes add REM_WAIT; search adds SCAN_RD, SCAN_CMP
// per entry compared; sorted insert scans, then SH_RD, SH_WR per moved ring entry, then PUT
// arst_n clears head, count and the result valid flag; ring contents start unknown
// a new beat is taken while a result waits; a stalled result holds the next one back
module sorted_circular_queue_top #(
	parameter int unsigned CAPACITY = scq_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [scq_pkg::OP_W-1:0]          opcode,
	input  logic signed [scq_pkg::VAL_W-1:0]  value,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic                              accepted,
	output logic                              found,
	output logic signed [scq_pkg::VAL_W-1:0]  front_value,
	output logic signed [scq_pkg::VAL_W-1:0]  rear_value,
	output logic [scq_pkg::OCC_W-1:0]         occupancy,
	output logic                              is_empty,
	output logic                              is_full
);
	import scq_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	scq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stat    (stat),
		.cmd     (cmd)
	);

	scq_dp #(
		.CAPACITY(CAPACITY)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.opcode     (opcode),
		.value      (value),
		.cmd        (cmd),
		.stat       (stat),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.accepted   (accepted),
		.found      (found),
		.front_value(front_value),
		.rear_value (rear_value),
		.occupancy  (occupancy),
		.is_empty   (is_empty),
		.is_full    (is_full)
	);

endmodule

FILE: design/scq_chk.sv
module scq_chk (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              out_valid,
	input logic                              out_ready,
	input logic                              accepted,
	input logic                              found,
	input logic signed [scq_pkg::VAL_W-1:0]  front_value,
	input logic signed [scq_pkg::VAL_W-1:0]  rear_value,
	input logic [scq_pkg::OCC_W-1:0]         occupancy,
	input logic                              is_empty,
	input logic                              is_full
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(accepted) && $stable(found)
			&& $stable(front_value) && $stable(rear_value) && $stable(occupancy)
			&& $stable(is_empty) && $stable(is_full))
		else $error("result beat changed while stalled");

	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_empty |-> front_value == '0 && rear_value == '0)
		else $error("empty queue shows stored values");

	a_found_acc: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && found |-> accepted && !is_empty)
		else $error("found without an accepted search");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_empty && is_full))
		else $error("empty and full together");

endmodule

bind sorted_circular_queue_top scq_chk u_chk (.*);

FILE: test/sorted_circular_queue_checker.sv
module sorted_circular_queue_checker #(
	parameter int unsigned CAPACITY = scq_pkg::CAPACITY_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic [scq_pkg::OP_W-1:0]          opcode,
	input  logic signed [scq_pkg::VAL_W-1:0]  value,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              accepted,
	input  logic                              found,
	input  logic signed [scq_pkg::VAL_W-1:0]  front_value,
	input  logic signed [scq_pkg::VAL_W-1:0]  rear_value,
	input  logic [scq_pkg::OCC_W-1:0]         occupancy,
	input  logic                              is_empty,
	input  logic                              is_full,
	output int                                mismatches,
	output int                                outstanding,
	output int                                results_seen
);
	timeunit 1ns;
	timeprecision 1ps;
	import scq_pkg::*;

	typedef struct packed {
		logic                    accepted;
		logic                    found;
		logic signed [VAL_W-1:0] front;
		logic signed [VAL_W-1:0] rear;
		logic [OCC_W-1:0]        occ;
		logic                    empty;
		logic                    full;
	} queue_status_t;

	logic signed [VAL_W-1:0] ring [CAPACITY];
	int unsigned             head;
	int unsigned             count;
	queue_status_t           expected_status [$];
	queue_status_t           want;

	function automatic int unsigned slot(int unsigned off);
		return (head + off) % CAPACITY;
	endfunction

	// updates the ring copy and returns the status the block should report
	function automatic queue_status_t apply_queue_op(op_t op, logic signed [VAL_W-1:0] v);
		queue_status_t s;
		int unsigned   pos;
		int unsigned   k;
		s = '0;
		case (op)
		OP_APPEND: begin
			if (count < CAPACITY) begin
				ring[slot(count)] = v;
				count++;
				s.accepted = 1'b1;
			end
		end
		OP_INSERT: begin
			if (count < CAPACITY) begin
				pos = 0;
				while (pos < count && !(ring[slot(pos)] > v))
					pos++;
				for (k = count; k > pos; k--)
					ring[slot(k)] = ring[slot(k - 1)];
				ring[slot(pos)] = v;
				count++;
				s.accepted = 1'b1;
			end
		end
		OP_REMOVE: begin
			if (count > 0) begin
				head = slot(1);
				count--;
				s.accepted = 1'b1;
			end
		end
		default: begin
			if (count > 0) begin
				s.accepted = 1'b1;
				for (k = 0; k < count; k++)
					if (ring[slot(k)] == v)
						s.found = 1'b1;
			end
		end
		endcase
		if (count > 0) begin
			s.front = ring[slot(0)];
			s.rear  = ring[slot(count - 1)];
		end
		s.occ   = count[OCC_W-1:0];
		s.empty = (count == 0);
		s.full  = (count == CAPACITY);
		return s;
	endfunction

	task automatic report_mismatch(string msg);
		mismatches++;
		$display("mismatch at %0t ns, result %0d: %s", $time, results_seen, msg);
	endtask

	task automatic check_field(string field, logic [VAL_W-1:0] seen, logic [VAL_W-1:0] exp_val);
		if (seen !== exp_val)
			report_mismatch($sformatf("%s got %h expected %h", field, seen, exp_val));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head = 0;
			count = 0;
			expected_status.delete();
			outstanding = 0;
		end else begin
			// compare the result beat before taking the new input beat
			if (out_valid && out_ready) begin
				results_seen++;
				if (expected_status.size() == 0) begin
					report_mismatch("result beat with nothing outstanding");
				end else begin
					want = expected_status.pop_front();
					check_field("accepted", VAL_W'(accepted), VAL_W'(want.accepted));
					check_field("found", VAL_W'(found), VAL_W'(want.found));
					check_field("front_value", front_value, want.front);
					check_field("rear_value", rear_value, want.rear);
					check_field("occupancy", VAL_W'(occupancy), VAL_W'(want.occ));
					check_field("is_empty", VAL_W'(is_empty), VAL_W'(want.empty));
					check_field("is_full", VAL_W'(is_full), VAL_W'(want.full));
				end
			end
			if (in_valid && in_ready)
				expected_status.push_back(apply_queue_op(op_t'(opcode), value));
			outstanding = expected_status.size();
		end
	end

endmodule

FILE: test/tb_sorted_circular_queue_top.sv
module tb_sorted_circular_queue_top;
	import scq_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic signed [VAL_W-1:0] MIN_VAL = 32'h8000_0000;
	localparam logic signed [VAL_W-1:0] MAX_VAL = 32'h7fff_ffff;
	localparam int RANDOM_PER_PHASE = 285;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic [OP_W-1:0]         opcode;
	logic signed [VAL_W-1:0] value;
	logic                    out_valid;
	logic                    out_ready;
	logic                    accepted;
	logic                    found;
	logic signed [VAL_W-1:0] front_value;
	logic signed [VAL_W-1:0] rear_value;
	logic [OCC_W-1:0]        occupancy;
	logic                    is_empty;
	logic                    is_full;

	int mismatches;
	int outstanding;
	int results_seen;
	int idle_pct;
	int stall_pct;
	int ops_sent [4];
	int phase;
	int n;
	int run_left;
	bit filling;

	sorted_circular_queue_top #(
		.CAPACITY(CAPACITY_DEF)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.found(found),
		.front_value(front_value),
		.rear_value(rear_value),
		.occupancy(occupancy),
		.is_empty(is_empty),
		.is_full(is_full)
	);

	sorted_circular_queue_checker #(
		.CAPACITY(CAPACITY_DEF)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.opcode(opcode),
		.value(value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.accepted(accepted),
		.found(found),
		.front_value(front_value),
		.rear_value(rear_value),
		.occupancy(occupancy),
		.is_empty(is_empty),
		.is_full(is_full),
		.mismatches(mismatches),
		.outstanding(outstanding),
		.results_seen(results_seen)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// valid stays high after a beat; the next call decides whether to idle
	task automatic send_beat(op_t op, logic signed [VAL_W-1:0] v);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		opcode   <= op;
		value    <= v;
		ops_sent[op]++;
		do @(posedge clk); while (!in_ready);
	endtask

	function automatic op_t pick_op(bit fill);
		int unsigned r;
		r = $urandom_range(99);
		if (fill) begin
			if (r < 35) return OP_APPEND;
			if (r < 70) return OP_INSERT;
			if (r < 85) return OP_SEARCH;
			return OP_REMOVE;
		end
		if (r < 55) return OP_REMOVE;
		if (r < 75) return OP_SEARCH;
		if (r < 87) return OP_APPEND;
		return OP_INSERT;
	endfunction

	// small values most of the time so that searches hit and inserts tie
	function automatic logic signed [VAL_W-1:0] pick_value();
		int unsigned r;
		r = $urandom_range(9);
		if (r < 5) return int'($urandom_range(16)) - 8;
		if (r < 8) return $urandom;
		case ($urandom_range(3))
		0: return MIN_VAL;
		1: return MAX_VAL;
		2: return '0;
		default: return '1;
		endcase
	endfunction

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		opcode    = OP_APPEND;
		value     = '0;
		out_ready = 1'b0;
		idle_pct  = 0;
		stall_pct = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// empty queue, sorted placement with ties, full refusals, drain
		send_beat(OP_REMOVE, 0);
		send_beat(OP_SEARCH, 0);
		send_beat(OP_INSERT, 5);
		send_beat(OP_INSERT, MIN_VAL);
		send_beat(OP_INSERT, MAX_VAL);
		send_beat(OP_INSERT, 5);
		send_beat(OP_INSERT, MAX_VAL);
		send_beat(OP_APPEND, -1);
		send_beat(OP_APPEND, 0);
		send_beat(OP_INSERT, 0);
		send_beat(OP_APPEND, 7);
		send_beat(OP_INSERT, 1);
		send_beat(OP_SEARCH, 5);
		send_beat(OP_SEARCH, 12345);
		send_beat(OP_SEARCH, -1);
		repeat (8) send_beat(OP_REMOVE, 0);
		send_beat(OP_REMOVE, 0);
		send_beat(OP_APPEND, 32'h5555_aaaa);

		filling = 1'b1;
		run_left = 0;
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
			0: begin
				idle_pct = 0;
				stall_pct = 0;
			end
			1: begin
				idle_pct = 45;
				stall_pct = 0;
			end
			2: begin
				idle_pct = 0;
				stall_pct = 45;
			end
			default: begin
				idle_pct = 10;
				stall_pct = 10;
			end
			endcase
			for (n = 0; n < RANDOM_PER_PHASE; n++) begin
				if (run_left == 0) begin
					filling = ~filling;
					run_left = $urandom_range(8, 40);
				end
				run_left--;
				send_beat(pick_op(filling), pick_value());
			end
		end
		@(negedge clk);
		in_valid <= 1'b0;

		while (outstanding != 0)
			@(negedge clk);
		repeat (30) @(negedge clk);

		$display("beats sent: %0d appends, %0d sorted inserts, %0d removes, %0d searches",
			ops_sent[OP_APPEND], ops_sent[OP_INSERT], ops_sent[OP_REMOVE], ops_sent[OP_SEARCH]);
		$display("%0d result beats compared under four idle and stall mixes, %0d mismatches",
			results_seen, mismatches);
		if (mismatches == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout: queue stopped responding");
		$display("Some tests failed");
		$finish;
	end

endmodule
